// ===== rtl/sfbt_pkg.sv =====
package sfbt_pkg;

    // Field widths
    localparam int LANES   = 4;
    localparam int GROUP_W = 2;
    localparam int ROWS    = 1 << GROUP_W;
    localparam int MAG_W   = 16;
    localparam int TIME_W  = 32;
    localparam int FLUX_W  = 20;
    localparam int THR_W   = 24;
    localparam int CONF_W  = 11;
    localparam int BPM_W   = 20;
    localparam int GAP_W   = 16;
    localparam int PHASE_W = 10;
    localparam int GAIN_W  = 12;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 2;

    // Frame layout: bins per frame, group that ends a frame
    localparam int BIN_COUNT  = 16;
    localparam int LAST_GROUP = BIN_COUNT / LANES - 1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GAIN    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SENS    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_GAP = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_GAP = 2'd3;

    // Constants
    localparam logic [FLUX_W-1:0]  FLUX_MAX      = 20'hFFFFF;
    localparam logic [THR_W-1:0]   THR_MAX       = 24'hFFFFFF;
    localparam logic [BPM_W-1:0]   BPM_MAX       = 20'hFFFFF;
    localparam logic [CONF_W-1:0]  CONF_ONE      = 11'd1024;
    localparam logic [PHASE_W-1:0] PHASE_MAX     = 10'd1022;
    localparam logic [BPM_W-1:0]   BPM_NUMERATOR = 20'd960000;
    localparam logic [BPM_W-1:0]   BPM_STEP      = 20'd80;
    localparam logic [GAP_W-1:0]   INTERVAL_INIT = 16'd500;
    localparam logic [BPM_W-1:0]   BPM_INIT      = 20'd1920;
    localparam logic [GAIN_W-1:0]  GAIN_INIT     = 12'd333;
    localparam logic [GAIN_W-1:0]  SENS_INIT     = 12'd256;
    localparam logic [GAP_W-1:0]   MIN_GAP_INIT  = 16'd250;
    localparam logic [GAP_W-1:0]   MAX_GAP_INIT  = 16'd2000;

    // Divide by five as multiply by ceil(2^22/5) and shift by 22, exact below 2^22
    localparam int                 FIFTH_SHIFT   = 22;
    localparam logic [19:0]        FIFTH_RECIP   = 20'd838861;

    typedef logic [LANES-1:0][MAG_W-1:0] bin_row_t;

    typedef struct packed {
        logic [GROUP_W-1:0] bin_group;
        logic [MAG_W-1:0]   bin_a;
        logic [MAG_W-1:0]   bin_b;
        logic [MAG_W-1:0]   bin_c;
        logic [MAG_W-1:0]   bin_d;
        logic [TIME_W-1:0]  time_ms;
    } in_item_t;

    typedef struct packed {
        logic               beat;
        logic [FLUX_W-1:0]  onset_flux;
        logic [THR_W-1:0]   level_threshold;
        logic [CONF_W-1:0]  confidence;
        logic [BPM_W-1:0]   tempo_bpm;
        logic               tempo_changed;
        logic [GAP_W-1:0]   beat_period;
        logic [PHASE_W-1:0] beat_phase;
    } out_item_t;

    // Write request into the bin store
    typedef struct packed {
        logic               en;
        logic [GROUP_W-1:0] addr;
        bin_row_t           data;
    } bin_wr_t;

endpackage

// ===== rtl/sfbt_div.sv =====
module sfbt_div #(
    parameter int NUM_W = 49,
    parameter int DEN_W = 24
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             busy,
    output logic             done,
    output logic [NUM_W-1:0] quo
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DEN_W:0]   shifted;
    logic [DEN_W:0]   diff;
    logic             ge;

    // One restoring step per cycle
    always_comb
    begin
        shifted   = {rem_reg, quo_reg[NUM_W-1]};
        diff      = shifted - {1'b0, den_reg};
        ge        = (shifted >= {1'b0, den_reg});
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = num;
            rem_next  = '0;
            cnt_next  = CNT_W'(NUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[NUM_W-2:0], ge};
            rem_next = ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start)
        begin
            den_reg <= den;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

// ===== rtl/sfbt_bins.sv =====
module sfbt_bins (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         rd_en,
    input  logic [sfbt_pkg::GROUP_W-1:0] rd_addr,
    input  sfbt_pkg::bin_wr_t            wr,
    output sfbt_pkg::bin_row_t           rd_data
);
    sfbt_pkg::bin_row_t mem [sfbt_pkg::ROWS];
    sfbt_pkg::bin_row_t rd_reg;
    logic [sfbt_pkg::ROWS-1:0] row_valid_reg;
    logic                      rd_valid_reg;

    // Row store, registered read
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            rd_reg <= mem[rd_addr];
        end
    end

    // Per-row valid bits: unwritten rows read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                row_valid_reg[wr.addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= row_valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_reg : '0;

endmodule

// ===== rtl/sfbt_hist.sv =====
module sfbt_hist #(
    parameter int DEPTH   = 32,
    parameter int TOTAL_W = 25,
    parameter int FILL_W  = 6
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    input  logic [sfbt_pkg::FLUX_W-1:0] flux,
    output logic [TOTAL_W-1:0]          total,
    output logic [FILL_W-1:0]           fill
);
    localparam int SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [sfbt_pkg::FLUX_W-1:0] mem [DEPTH];
    logic [sfbt_pkg::FLUX_W-1:0] old_reg;
    logic [sfbt_pkg::FLUX_W-1:0] flux_reg;
    logic                        upd_reg;
    logic [TOTAL_W-1:0]          total_reg;
    logic [FILL_W-1:0]           fill_reg;
    logic [SLOT_W-1:0]           slot_reg;
    logic                        full;

    assign full = (fill_reg == FILL_W'(DEPTH));

    // Read the outgoing entry on push, write the new one in the next cycle
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            old_reg  <= mem[slot_reg];
            flux_reg <= flux;
        end
        if (upd_reg)
        begin
            mem[slot_reg] <= flux_reg;
        end
    end

    // Running total, fill count and write slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upd_reg   <= 1'b0;
            total_reg <= '0;
            fill_reg  <= '0;
            slot_reg  <= '0;
        end
        else
        begin
            upd_reg <= push;
            if (upd_reg)
            begin
                total_reg <= total_reg - (full ? TOTAL_W'(old_reg) : '0)
                             + TOTAL_W'(flux_reg);
                if (!full)
                begin
                    fill_reg <= fill_reg + 1'b1;
                end
                slot_reg <= (slot_reg == SLOT_W'(DEPTH - 1)) ? '0 : slot_reg + 1'b1;
            end
        end
    end

    assign total = total_reg;
    assign fill  = fill_reg;

    // Fill never passes the depth
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(DEPTH))
        else $error("history fill beyond depth");

    // Update follows each push in the next cycle
    a_push_upd: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> upd_reg)
        else $error("history update missing");

    // No push while an update is pending
    a_push_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        upd_reg |-> !push)
        else $error("history push overlaps update");

endmodule

// ===== rtl/spectral_flux_beat_tracker_core.sv =====
// Channel | Direction | Handshake                    | Payload
// in      | input     | in_valid / in_ready          | in_item (sfbt_pkg::in_item_t)
// out     | output    | out_valid / out_ready        | out_item (sfbt_pkg::out_item_t)
// cfg     | input     | cfg_write (no wait)          | cfg_index, cfg_data
//
// A non-final group does a bin row read, then the rise sum and write back.
// A frame-ending group adds the history update, the threshold product and up to four
// divisions on one shared bit-serial divider.
// Reset clears bin rows through per-row valid bits; no clearing pass is run.
// A finished result waits in the output register while the next item is taken;
// the block stalls only when a new result is ready and that register is full.
module spectral_flux_beat_tracker_core #(
    parameter int HISTORY_DEPTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  sfbt_pkg::in_item_t            in_item,
    output logic                          out_valid,
    input  logic                          out_ready,
    output sfbt_pkg::out_item_t           out_item,
    input  logic                          cfg_write,
    input  logic [sfbt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sfbt_pkg::CFG_W-1:0]    cfg_data
);
    localparam int TOTAL_W    = sfbt_pkg::FLUX_W + $clog2(HISTORY_DEPTH);
    localparam int FILL_W     = $clog2(HISTORY_DEPTH + 1);
    localparam int PROD_W     = TOTAL_W + sfbt_pkg::GAIN_W;
    localparam int NUM_W      = PROD_W + sfbt_pkg::GAIN_W;
    localparam int DEN_W      = sfbt_pkg::THR_W;
    localparam int ACC_W      = sfbt_pkg::FLUX_W;
    localparam int ISUM_W     = sfbt_pkg::GAP_W + 3;
    localparam int IPROD_W    = ISUM_W + 20;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_BIN    = 4'd1;
    localparam logic [3:0] S_WAIT   = 4'd2;
    localparam logic [3:0] S_HIST1  = 4'd3;
    localparam logic [3:0] S_HIST2  = 4'd4;
    localparam logic [3:0] S_MUL    = 4'd5;
    localparam logic [3:0] S_DECIDE = 4'd6;
    localparam logic [3:0] S_TEMPO  = 4'd7;
    localparam logic [3:0] S_BPM    = 4'd8;
    localparam logic [3:0] S_PHASE  = 4'd9;
    localparam logic [3:0] S_DONE   = 4'd10;

    localparam logic [2:0] OP_THR   = 3'd1;
    localparam logic [2:0] OP_CONF  = 3'd2;
    localparam logic [2:0] OP_BPM   = 3'd4;
    localparam logic [2:0] OP_PHASE = 3'd5;

    logic [3:0] state_reg, state_next;
    logic [2:0] op_reg, op_next;

    sfbt_pkg::in_item_t  item_reg, item_next;
    sfbt_pkg::out_item_t out_reg, out_next;
    logic                out_valid_reg, out_valid_next;

    logic [sfbt_pkg::GAIN_W-1:0] gain_reg, sens_reg;
    logic [sfbt_pkg::GAP_W-1:0]  min_gap_reg, max_gap_reg;

    logic [ACC_W-1:0]             acc_reg, acc_next;
    logic [sfbt_pkg::FLUX_W-1:0]  flux_reg, flux_next;
    logic [sfbt_pkg::THR_W-1:0]   thr_reg, thr_next;
    logic [sfbt_pkg::TIME_W-1:0]  gap_reg, gap_next;
    logic                         beat_reg, beat_next;
    logic                         changed_reg, changed_next;
    logic [sfbt_pkg::CONF_W-1:0]  conf_reg, conf_next;
    logic [sfbt_pkg::TIME_W-1:0]  last_reg, last_next;
    logic [sfbt_pkg::GAP_W-1:0]   int_reg, int_next;
    logic [sfbt_pkg::BPM_W-1:0]   bpm_reg, bpm_next;
    logic [sfbt_pkg::PHASE_W-1:0] phase_reg, phase_next;
    logic [PROD_W-1:0]            prod_reg, prod_next;

    // Divider and stores
    logic             div_start, div_busy, div_done;
    logic [NUM_W-1:0] div_num, div_quo;
    logic [DEN_W-1:0] div_den;
    logic             bins_rd;
    sfbt_pkg::bin_wr_t  bins_wr;
    sfbt_pkg::bin_row_t bins_prev;
    logic               hist_push;
    logic [TOTAL_W-1:0] hist_total;
    logic [FILL_W-1:0]  hist_fill;

    // Scratch
    logic [sfbt_pkg::MAG_W-1:0]  mag [sfbt_pkg::LANES];
    logic [sfbt_pkg::MAG_W+1:0]  rise_sum;
    logic [ACC_W:0]              acc_sum;
    logic [ACC_W-1:0]            acc_sat;
    logic                        is_last;
    logic [sfbt_pkg::TIME_W-1:0] gap_now, elapsed;
    logic                        beat_now;
    logic [sfbt_pkg::BPM_W-1:0]  bpm_new;
    logic [ISUM_W-1:0]           intv_sum;
    logic [IPROD_W-1:0]          intv_prod;

    function automatic logic tempo_moved(input logic [sfbt_pkg::BPM_W-1:0] a,
                                         input logic [sfbt_pkg::BPM_W-1:0] b);
        logic [sfbt_pkg::BPM_W-1:0] d;
        d = (a > b) ? a - b : b - a;
        return d > sfbt_pkg::BPM_STEP;
    endfunction

    sfbt_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .busy  (div_busy),
        .done  (div_done),
        .quo   (div_quo)
    );

    sfbt_bins u_bins (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (bins_rd),
        .rd_addr (in_item.bin_group),
        .wr      (bins_wr),
        .rd_data (bins_prev)
    );

    sfbt_hist #(.DEPTH(HISTORY_DEPTH), .TOTAL_W(TOTAL_W), .FILL_W(FILL_W)) u_hist (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (hist_push),
        .flux  (flux_next),
        .total (hist_total),
        .fill  (hist_fill)
    );

    // Rise sum over the four lanes of the held item
    always_comb
    begin
        mag[0] = item_reg.bin_a;
        mag[1] = item_reg.bin_b;
        mag[2] = item_reg.bin_c;
        mag[3] = item_reg.bin_d;
        rise_sum = '0;
        bins_wr.en   = 1'b0;
        bins_wr.addr = item_reg.bin_group;
        for (int l = 0; l < sfbt_pkg::LANES; l++)
        begin
            bins_wr.data[l] = bins_prev[l];
            if (int'(item_reg.bin_group) * sfbt_pkg::LANES + l < sfbt_pkg::BIN_COUNT)
            begin
                bins_wr.data[l] = mag[l];
                if (mag[l] > bins_prev[l])
                begin
                    rise_sum = rise_sum + (sfbt_pkg::MAG_W + 2)'(mag[l] - bins_prev[l]);
                end
            end
        end
        acc_sum = {1'b0, acc_reg} + (ACC_W + 1)'(rise_sum);
        acc_sat = acc_sum[ACC_W] ? {ACC_W{1'b1}} : acc_sum[ACC_W-1:0];
        is_last = (int'(item_reg.bin_group) == sfbt_pkg::LAST_GROUP);
        if (state_reg == S_BIN)
        begin
            bins_wr.en = 1'b1;
        end
    end

    // Frame sequencer
    always_comb
    begin
        state_next   = state_reg;
        op_next      = op_reg;
        item_next    = item_reg;
        acc_next     = acc_reg;
        flux_next    = flux_reg;
        thr_next     = thr_reg;
        gap_next     = gap_reg;
        beat_next    = beat_reg;
        changed_next = changed_reg;
        conf_next    = conf_reg;
        last_next    = last_reg;
        int_next     = int_reg;
        bpm_next     = bpm_reg;
        phase_next   = phase_reg;
        prod_next    = prod_reg;
        out_next     = out_reg;
        out_valid_next = out_valid_reg && !out_ready;
        div_start    = 1'b0;
        div_num      = '0;
        div_den      = '0;
        bins_rd      = 1'b0;
        hist_push    = 1'b0;
        gap_now      = item_reg.time_ms - last_reg;
        elapsed      = item_reg.time_ms - last_reg;
        beat_now     = ({4'b0, flux_reg} > thr_reg) &&
                       (gap_now >= sfbt_pkg::TIME_W'(min_gap_reg));
        bpm_new      = sfbt_pkg::BPM_MAX;
        // interval = (gap + 4*interval) / 5 by reciprocal multiply
        intv_sum     = ISUM_W'(gap_reg[sfbt_pkg::GAP_W-1:0]) + ISUM_W'({int_reg, 2'b0});
        intv_prod    = IPROD_W'(intv_sum) * IPROD_W'(sfbt_pkg::FIFTH_RECIP);

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    item_next  = in_item;
                    bins_rd    = 1'b1;
                    state_next = S_BIN;
                end
            end
            S_BIN:
            begin
                if (is_last)
                begin
                    // flux = acc * 16 / BIN_COUNT, which is the accumulator itself
                    acc_next     = '0;
                    changed_next = 1'b0;
                    beat_next    = 1'b0;
                    flux_next    = acc_sat;
                    hist_push    = 1'b1;
                    state_next   = S_HIST1;
                end
                else
                begin
                    acc_next   = acc_sat;
                    state_next = S_IDLE;
                end
            end
            S_WAIT:
            begin
                if (div_done)
                begin
                    unique case (op_reg)
                        OP_THR:
                        begin
                            thr_next = (div_quo[NUM_W-1:16] > (NUM_W - 16)'(sfbt_pkg::THR_MAX)) ?
                                       sfbt_pkg::THR_MAX : div_quo[sfbt_pkg::THR_W+15:16];
                            state_next = S_DECIDE;
                        end
                        OP_CONF:
                        begin
                            conf_next = (div_quo > NUM_W'(sfbt_pkg::CONF_ONE)) ?
                                        sfbt_pkg::CONF_ONE : div_quo[sfbt_pkg::CONF_W-1:0];
                            state_next = S_TEMPO;
                        end
                        OP_BPM:
                        begin
                            bpm_new      = div_quo[sfbt_pkg::BPM_W-1:0];
                            changed_next = tempo_moved(bpm_new, bpm_reg);
                            bpm_next     = bpm_new;
                            state_next   = S_PHASE;
                        end
                        OP_PHASE:
                        begin
                            phase_next = (div_quo > NUM_W'(sfbt_pkg::PHASE_MAX)) ?
                                         sfbt_pkg::PHASE_MAX :
                                         div_quo[sfbt_pkg::PHASE_W-1:0];
                            state_next = S_DONE;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_HIST1:
            begin
                state_next = S_HIST2;
            end
            S_HIST2:
            begin
                // total * gain, registered before the second product
                prod_next  = PROD_W'(hist_total) * PROD_W'(gain_reg);
                state_next = S_MUL;
            end
            S_MUL:
            begin
                div_start  = 1'b1;
                div_num    = NUM_W'(prod_reg) * NUM_W'(sens_reg);
                div_den    = DEN_W'(hist_fill);
                op_next    = OP_THR;
                state_next = S_WAIT;
            end
            S_DECIDE:
            begin
                gap_next  = gap_now;
                beat_next = beat_now;
                if (!beat_now)
                begin
                    state_next = S_PHASE;
                end
                else if (thr_reg == '0)
                begin
                    conf_next  = sfbt_pkg::CONF_ONE;
                    state_next = S_TEMPO;
                end
                else
                begin
                    div_start  = 1'b1;
                    div_num    = NUM_W'({flux_reg - thr_reg[sfbt_pkg::FLUX_W-1:0], 10'b0});
                    div_den    = thr_reg;
                    op_next    = OP_CONF;
                    state_next = S_WAIT;
                end
            end
            S_TEMPO:
            begin
                last_next = item_reg.time_ms;
                if (gap_reg <= sfbt_pkg::TIME_W'(max_gap_reg))
                begin
                    int_next   = intv_prod[sfbt_pkg::FIFTH_SHIFT +: sfbt_pkg::GAP_W];
                    state_next = S_BPM;
                end
                else
                begin
                    state_next = S_PHASE;
                end
            end
            S_BPM:
            begin
                if (int_reg == '0)
                begin
                    changed_next = tempo_moved(bpm_new, bpm_reg);
                    bpm_next     = bpm_new;
                    state_next   = S_PHASE;
                end
                else
                begin
                    div_start  = 1'b1;
                    div_num    = NUM_W'(sfbt_pkg::BPM_NUMERATOR);
                    div_den    = DEN_W'(int_reg);
                    op_next    = OP_BPM;
                    state_next = S_WAIT;
                end
            end
            S_PHASE:
            begin
                if (int_reg == '0)
                begin
                    phase_next = '0;
                    state_next = S_DONE;
                end
                else if (elapsed >= sfbt_pkg::TIME_W'(int_reg))
                begin
                    phase_next = sfbt_pkg::PHASE_MAX;
                    state_next = S_DONE;
                end
                else
                begin
                    div_start  = 1'b1;
                    div_num    = NUM_W'({elapsed[sfbt_pkg::GAP_W-1:0], 10'b0});
                    div_den    = DEN_W'(int_reg);
                    op_next    = OP_PHASE;
                    state_next = S_WAIT;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_next.beat            = beat_reg;
                    out_next.onset_flux      = flux_reg;
                    out_next.level_threshold = thr_reg;
                    out_next.confidence      = conf_reg;
                    out_next.tempo_bpm       = bpm_reg;
                    out_next.tempo_changed   = changed_reg;
                    out_next.beat_period     = int_reg;
                    out_next.beat_phase      = phase_reg;
                    out_valid_next           = 1'b1;
                    state_next               = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control and tracker state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= OP_THR;
            out_valid_reg <= 1'b0;
            gain_reg      <= sfbt_pkg::GAIN_INIT;
            sens_reg      <= sfbt_pkg::SENS_INIT;
            min_gap_reg   <= sfbt_pkg::MIN_GAP_INIT;
            max_gap_reg   <= sfbt_pkg::MAX_GAP_INIT;
            acc_reg       <= '0;
            conf_reg      <= '0;
            last_reg      <= '0;
            int_reg       <= sfbt_pkg::INTERVAL_INIT;
            bpm_reg       <= sfbt_pkg::BPM_INIT;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            out_valid_reg <= out_valid_next;
            acc_reg       <= acc_next;
            conf_reg      <= conf_next;
            last_reg      <= last_next;
            int_reg       <= int_next;
            bpm_reg       <= bpm_next;
            if (cfg_write)
            begin
                unique case (cfg_index)
                    sfbt_pkg::REG_GAIN:    gain_reg    <= cfg_data[sfbt_pkg::GAIN_W-1:0];
                    sfbt_pkg::REG_SENS:    sens_reg    <= cfg_data[sfbt_pkg::GAIN_W-1:0];
                    sfbt_pkg::REG_MIN_GAP: min_gap_reg <= cfg_data;
                    sfbt_pkg::REG_MAX_GAP: max_gap_reg <= cfg_data;
                endcase
            end
        end
    end

    // Per-frame payload
    always_ff @(posedge clk)
    begin
        item_reg    <= item_next;
        out_reg     <= out_next;
        flux_reg    <= flux_next;
        thr_reg     <= thr_next;
        gap_reg     <= gap_next;
        beat_reg    <= beat_next;
        changed_reg <= changed_next;
        phase_reg   <= phase_next;
        prod_reg    <= prod_next;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    // Divider is only launched when idle
    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    // Waiting implies a division in flight or just finished
    a_wait_div: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WAIT) |-> (div_busy || div_done))
        else $error("waiting with no division running");

    // An accepted item goes straight to the bin update
    a_accept_bin: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_BIN))
        else $error("accepted item not processed");

    // A result is only loaded when the output slot is free
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && out_valid_reg && !out_ready) |=> (state_reg == S_DONE))
        else $error("pending result overwritten");

endmodule
